// ===== hdl/fmprc_pkg.sv =====
// fmprc_pkg: shared types, codes and defaults of the first-match rule classifier
// used by first_match_packet_rule_classifier_top; no dependencies

package fmprc_pkg;

   localparam int RULES_DEFAULT  = 16;
   localparam int CHAINS_DEFAULT = 2;

   localparam int MODE_W     = 2;
   localparam int CHAIN_W    = 2;
   localparam int MASK_W     = 6;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 8;
   localparam int REQ_USER_W = MODE_W + CHAIN_W;
   localparam int RSP_DATA_W = 8;

   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;

   localparam logic VERDICT_ACCEPT = 1'b0;

   localparam int EN_SADDR = 0;
   localparam int EN_DADDR = 1;
   localparam int EN_PROTO = 2;
   localparam int EN_ICMP  = 3;
   localparam int EN_SPORT = 4;
   localparam int EN_DPORT = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_INPUT  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_OUTPUT = 8'd1;

   typedef enum logic [MODE_W-1:0] {
      MODE_CLASSIFY = 2'd0,
      MODE_APPEND   = 2'd1,
      MODE_FLUSH    = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_CHAIN = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // lowest field last
   typedef struct packed {
      logic              rule_action;
      logic [15:0]       dst_port;
      logic [15:0]       src_port;
      logic [7:0]        icmp_kind;
      logic [7:0]        protocol;
      logic [31:0]       dst_addr;
      logic [31:0]       src_addr;
      logic [MASK_W-1:0] filter_mask;
   } rule_type;

   localparam int RULE_W     = $bits(rule_type);
   localparam int REQ_DATA_W = ((RULE_W + 7) / 8) * 8;

endpackage

// ===== hdl/first_match_packet_rule_classifier_top.sv =====
// first_match_packet_rule_classifier_top: ordered per-chain rule lists in one rule memory,
// first-match classify scan, append and flush; depends on fmprc_pkg
//
// usage:
//   req channel: one request per item; tuser carries mode and chain, tdata the rule or
//   packet fields. rsp channel: one result per request, verdict and status in tdata.
//   csr channel: default verdict writes, always ready, index 0 input chain, 1 output chain.
//   only write csr while no request is in flight.
// timing:
//   append, flush, bad chain, empty chain and unknown mode: the result is loaded into the
//   result register from the request. classify: the request issues the first rule read,
//   then the scan checks each rule read from the rule memory in turn until the first hit
//   or the last rule. in every mode the result waits in the block while the result register
//   is still held. the next request is taken once the previous one has finished.
// reset clears rule counts, default verdicts and the result valid; rule memory keeps its
// contents. a stalled rsp holds its result; a finished item waits in the block until the
// result register frees, and no request is taken meanwhile.

module first_match_packet_rule_classifier_top
   #(
      parameter int RULES  = fmprc_pkg::RULES_DEFAULT,
      parameter int CHAINS = fmprc_pkg::CHAINS_DEFAULT
   )
   (
      input  logic                                 clock,
      input  logic                                 reset,
      input  logic                                 req_tvalid,
      output logic                                 req_tready,
      // filter_mask, src_addr, dst_addr, protocol, icmp_kind, src_port, dst_port,
      // rule_action, zero pad
      input  logic [fmprc_pkg::REQ_DATA_W-1:0]     req_tdata,
      // mode, chain
      input  logic [fmprc_pkg::REQ_USER_W-1:0]     req_tuser,
      output logic                                 rsp_tvalid,
      input  logic                                 rsp_tready,
      // verdict, status, zero pad
      output logic [fmprc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
      input  logic                                 csr_valid,
      output logic                                 csr_ready,
      input  logic [fmprc_pkg::CSR_IDX_W-1:0]      csr_index,
      input  logic                                 csr_data
   );

   import fmprc_pkg::*;

   localparam int DEPTH  = CHAINS * RULES;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_W  = (RULES > 1) ? $clog2(RULES) : 1;
   localparam int CNT_W  = $clog2(RULES + 1);

   rule_type               mem [DEPTH];
   rule_type               rd_data_ff;
   logic [ADDR_W-1:0]      rd_addr;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;

   state_type              state_ff, state_in;
   rule_type               pkt_ff, pkt_in;
   logic                   chain_ff, chain_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       count_ff [CHAINS];
   logic [CNT_W-1:0]       count_in [CHAINS];
   logic                   res_verdict_ff, res_verdict_in;
   status_type             res_status_ff, res_status_in;
   logic                   rsp_valid_ff;
   logic                   rsp_verdict_ff;
   status_type             rsp_status_ff;
   logic                   dflt_input_ff;
   logic                   dflt_output_ff;

   rule_type               req_rule;
   mode_type               req_mode;
   logic                   req_chain;
   logic                   req_chain_ok;
   logic                   slot_free;
   logic                   rsp_load;
   logic                   finish;
   logic                   fin_verdict;
   status_type             fin_status;
   logic                   hit;
   logic                   last;
   logic [CNT_W-1:0]       cur_count;

   function automatic logic chain_base_sel(input logic ch);
      chain_base_sel = ch;
   endfunction

   function automatic logic [ADDR_W-1:0] rule_addr(input logic ch, input logic [IDX_W-1:0] idx);
      logic [ADDR_W-1:0] base;
      base = chain_base_sel(ch) ? ADDR_W'(RULES) : '0;
      rule_addr = base + ADDR_W'(idx);
   endfunction

   function automatic logic rule_hits(input rule_type r, input rule_type p);
      logic ok;
      ok = !(r.filter_mask[EN_SADDR] && (r.src_addr != p.src_addr))
        && !(r.filter_mask[EN_DADDR] && (r.dst_addr != p.dst_addr))
        && !(r.filter_mask[EN_PROTO] && (r.protocol != p.protocol));
      if (p.protocol == PROTO_ICMP) begin
         ok = ok && !(r.filter_mask[EN_ICMP] && (r.icmp_kind != p.icmp_kind));
      end else if ((p.protocol == PROTO_TCP) || (p.protocol == PROTO_UDP)) begin
         ok = ok && !(r.filter_mask[EN_SPORT] && (r.src_port != p.src_port))
                 && !(r.filter_mask[EN_DPORT] && (r.dst_port != p.dst_port));
      end else begin
         ok = 1'b0;
      end
      rule_hits = ok;
   endfunction

   assign req_rule     = rule_type'(req_tdata[RULE_W-1:0]);
   assign req_mode     = mode_type'(req_tuser[MODE_W-1:0]);
   assign req_chain    = req_tuser[MODE_W];
   assign req_chain_ok = 32'(req_tuser[REQ_USER_W-1:MODE_W]) < CHAINS;
   assign slot_free    = !rsp_valid_ff || rsp_tready;
   assign cur_count    = count_ff[chain_ff];
   assign hit          = rule_hits(rd_data_ff, pkt_ff);
   assign last         = (CNT_W'(idx_ff) + CNT_W'(1)) == cur_count;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - STATUS_W - 1)'(0), rsp_status_ff, rsp_verdict_ff};

   always_comb begin
      state_in       = state_ff;
      pkt_in         = pkt_ff;
      chain_in       = chain_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      res_verdict_in = res_verdict_ff;
      res_status_in  = res_status_ff;
      req_tready     = 1'b0;
      rd_addr        = rule_addr(chain_ff, idx_ff + IDX_W'(1));
      wr_en          = 1'b0;
      wr_addr        = rule_addr(req_chain, IDX_W'(count_ff[req_chain]));
      finish         = 1'b0;
      fin_verdict    = VERDICT_ACCEPT;
      fin_status     = STATUS_OK;
      rsp_load       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               pkt_in   = req_rule;
               chain_in = req_chain;
               finish   = 1'b1;
               case (req_mode)
                  MODE_CLASSIFY: begin
                     if (!req_chain_ok) begin
                        fin_status = STATUS_BAD_CHAIN;
                     end else if (count_ff[req_chain] == '0) begin
                        fin_verdict = req_chain ? dflt_output_ff : dflt_input_ff;
                     end else begin
                        finish   = 1'b0;
                        idx_in   = '0;
                        rd_addr  = rule_addr(req_chain, '0);
                        state_in = ST_SCAN;
                     end
                  end
                  MODE_APPEND: begin
                     if (!req_chain_ok) begin
                        fin_status = STATUS_BAD_CHAIN;
                     end else if (count_ff[req_chain] >= CNT_W'(RULES)) begin
                        fin_status = STATUS_FULL;
                     end else begin
                        wr_en = 1'b1;
                        count_in[req_chain] = count_ff[req_chain] + CNT_W'(1);
                     end
                  end
                  MODE_FLUSH: begin
                     if (!req_chain_ok) begin
                        fin_status = STATUS_BAD_CHAIN;
                     end else begin
                        count_in[req_chain] = '0;
                     end
                  end
                  default: begin
                     fin_status = STATUS_OK;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (hit) begin
               finish      = 1'b1;
               fin_verdict = rd_data_ff.rule_action;
            end else if (last) begin
               finish      = 1'b1;
               fin_verdict = chain_ff ? dflt_output_ff : dflt_input_ff;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (finish) begin
         res_verdict_in = fin_verdict;
         res_status_in  = fin_status;
         if (slot_free) begin
            rsp_load = 1'b1;
            state_in = ST_IDLE;
         end else begin
            state_in = ST_EMIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_rule;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         dflt_input_ff  <= 1'b0;
         dflt_output_ff <= 1'b0;
         for (int c = 0; c < CHAINS; c++) begin
            count_ff[c] <= '0;
         end
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && (csr_index == CSR_DEFAULT_INPUT)) begin
            dflt_input_ff <= csr_data;
         end
         if (csr_valid && (csr_index == CSR_DEFAULT_OUTPUT)) begin
            dflt_output_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pkt_ff         <= pkt_in;
      chain_ff       <= chain_in;
      idx_ff         <= idx_in;
      res_verdict_ff <= res_verdict_in;
      res_status_ff  <= res_status_in;
      if (rsp_load) begin
         rsp_verdict_ff <= res_verdict_in;
         rsp_status_ff  <= res_status_in;
      end
   end

endmodule
